### hw/rtl/modexp_pkg.sv
// Shared types, constants and control structures for the modular exponentiation core.
// Depends on nothing; every other file of the core refers to it by scoped names.

package modexp_pkg;

	// Default configuration of the core.
	localparam int MOD_WIDTH_DEF = 31;
	localparam int EXP_WIDTH_DEF = 63;

	// Fixed field widths.
	localparam int BASE_WIDTH   = 63;
	localparam int RESULT_WIDTH = 31;

	// Modulus after reset, truncated to the configured width where it is used.
	localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

	// Step counter covers the longest pass, which is the base reduction.
	localparam int CNT_WIDTH = $clog2(BASE_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_MUL,
		ST_SQR,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		OP_REDUCE,
		OP_MUL,
		OP_SQR
	} op_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic in_valid;
		logic skip;
		logic exp_zero;
		logic exp_lsb;
		logic exp_last;
		logic out_free;
	} status_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic in_ready;
		logic load;
		logic step;
		logic last;
		op_t  op;
		logic start_mul;
		logic start_sqr;
		logic shift_exp;
		logic finish;
	} ctrl_t;

endpackage

### hw/rtl/modexp_if.sv
// Valid/ready channel interfaces for the operand and result transfers of the core.
// Depends on modexp_pkg for the default exponent width and the base and result widths.

interface modexp_in_if #(
	parameter int EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEF
);
	logic                                valid;
	logic                                ready;
	logic [modexp_pkg::BASE_WIDTH-1:0]   base_value;
	logic [EXP_WIDTH-1:0]                exponent;

	modport source (output valid, output base_value, output exponent, input ready);
	modport sink (input valid, input base_value, input exponent, output ready);
endinterface

interface modexp_out_if;
	logic                                valid;
	logic                                ready;
	logic [modexp_pkg::RESULT_WIDTH-1:0] power_result;

	modport source (output valid, output power_result, input ready);
	modport sink (input valid, input power_result, output ready);
endinterface

### hw/rtl/modular_exponentiation_core.sv
// Modular exponentiation core: result = base_value ** exponent mod modulus, by
// right-to-left binary square-and-multiply. One operand transfer is taken while the core is
// idle; the core then drops ready until the result has been computed. A single shared unit,
// one modular doubling-and-add step per clock, does all arithmetic: the 63-bit base is first
// reduced modulo the modulus, then every exponent bit costs a check, a multiply pass when the
// bit is set, and a square pass (left out after the highest set bit). An exponent of zero
// yields 1 (for any modulus) and a modulus of zero yields 0; both skip the arithmetic and go
// from the operand transfer straight to the finishing state. The result waits in an output
// register, so the next operand transfer may be taken while the previous result has not yet
// been collected. The modulus register resets to 1000000007 and is written through
// modulus_we/modulus_wdata; it must only be written while the core is idle.

module modular_exponentiation_core #(
	parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF,
	parameter int EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 modulus_we,
	input  logic [MOD_WIDTH-1:0] modulus_wdata,
	modexp_in_if.sink            operands,
	modexp_out_if.source         result
);

	localparam int BW = modexp_pkg::BASE_WIDTH;

	modexp_pkg::status_t status;
	modexp_pkg::ctrl_t   ctrl;

	// Configuration.
	logic [MOD_WIDTH-1:0] modulus_q;

	// Datapath registers.
	logic [EXP_WIDTH-1:0] exp_q;
	logic [MOD_WIDTH-1:0] base_q;
	logic [MOD_WIDTH-1:0] acc_q;
	logic [MOD_WIDTH-1:0] rem_q;
	logic [BW-1:0]        opnd_q;

	// Output register.
	logic                                 out_valid_q;
	logic [modexp_pkg::RESULT_WIDTH-1:0]  power_result_q;

	logic [MOD_WIDTH-1:0] addend;
	logic [MOD_WIDTH-1:0] rem_next;
	logic [MOD_WIDTH-1:0] acc_init;

	// The multiply pass shifts its first operand out from the top of the operand register.
	localparam int PAD_WIDTH = BW - MOD_WIDTH;

	// The configuration register is the only state that must survive between items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_WIDTH'(modexp_pkg::MODULUS_RESET);
		end else if (modulus_we) begin
			modulus_q <= modulus_wdata;
		end
	end

	// Status seen by the sequencer. An item with a zero exponent or a zero modulus needs no
	// arithmetic at all, and the initial accumulator already holds its answer.
	always_comb begin
		status.in_valid = operands.valid;
		status.skip     = (operands.exponent == '0) || (modulus_q == '0);
		status.exp_zero = (exp_q == '0);
		status.exp_lsb  = exp_q[0];
		status.exp_last = (exp_q[EXP_WIDTH-1:1] == '0);
		status.out_free = !out_valid_q || result.ready;
	end

	// The accumulator starts at 1 mod m, except that a zero exponent always gives 1.
	always_comb begin
		if (operands.exponent == '0) begin
			acc_init = MOD_WIDTH'(1);
		end else if (modulus_q > MOD_WIDTH'(1)) begin
			acc_init = MOD_WIDTH'(1);
		end else begin
			acc_init = '0;
		end
	end

	// Reducing the base folds in one bit of weight one per step; the multiply and square
	// passes fold in the current base.
	assign addend = (ctrl.op == modexp_pkg::OP_REDUCE) ? MOD_WIDTH'(1) : base_q;

	modexp_ctrl #(
		.MOD_WIDTH (MOD_WIDTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	modexp_step #(
		.MOD_WIDTH (MOD_WIDTH)
	) u_step (
		.rem      (rem_q),
		.bit_in   (opnd_q[BW-1]),
		.addend   (addend),
		.modulus  (modulus_q),
		.rem_next (rem_next)
	);

	// Datapath. A pass start takes priority over the step, since a multiply finishes and the
	// square begins in the same cycle.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			opnd_q <= operands.base_value;
			rem_q  <= '0;
		end else if (ctrl.start_mul) begin
			opnd_q <= {acc_q, {PAD_WIDTH{1'b0}}};
			rem_q  <= '0;
		end else if (ctrl.start_sqr) begin
			opnd_q <= {base_q, {PAD_WIDTH{1'b0}}};
			rem_q  <= '0;
		end else if (ctrl.step) begin
			rem_q  <= rem_next;
			opnd_q <= {opnd_q[BW-2:0], 1'b0};
		end
		if (ctrl.load) begin
			acc_q <= acc_init;
		end else if (ctrl.step && ctrl.last) begin
			case (ctrl.op)
				modexp_pkg::OP_REDUCE: base_q <= rem_next;
				modexp_pkg::OP_MUL:    acc_q  <= rem_next;
				modexp_pkg::OP_SQR:    base_q <= rem_next;
				default:               base_q <= base_q;
			endcase
		end
		if (ctrl.load) begin
			exp_q <= operands.exponent;
		end else if (ctrl.shift_exp) begin
			exp_q <= exp_q >> 1;
		end
		if (ctrl.finish) begin
			power_result_q <= modexp_pkg::RESULT_WIDTH'(acc_q);
		end
	end

	// The result stays valid until its transfer; a new result is only written once the
	// register is free or being emptied in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign operands.ready      = ctrl.in_ready;
	assign result.valid        = out_valid_q;
	assign result.power_result = power_result_q;

endmodule

### hw/rtl/modexp_step.sv
// One step of the shared interleaved modular multiplier: r' = (2r + bit*addend) mod m.
// Depends on modexp_pkg for the default width; operands must already lie below the modulus.

module modexp_step #(
	parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF
) (
	input  logic [MOD_WIDTH-1:0] rem,
	input  logic                 bit_in,
	input  logic [MOD_WIDTH-1:0] addend,
	input  logic [MOD_WIDTH-1:0] modulus,
	output logic [MOD_WIDTH-1:0] rem_next
);

	logic [MOD_WIDTH:0] mod_ext;
	logic [MOD_WIDTH:0] dbl;
	logic [MOD_WIDTH:0] dbl_red;
	logic [MOD_WIDTH:0] sum;
	logic [MOD_WIDTH:0] sum_red;

	always_comb begin
		mod_ext = {1'b0, modulus};
		// Doubling a value below m stays below 2m, so one subtraction reduces it.
		dbl     = {rem, 1'b0};
		dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
		// The addend is at most m, so again one subtraction suffices.
		sum     = dbl_red + (bit_in ? {1'b0, addend} : '0);
		sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
		rem_next = sum_red[MOD_WIDTH-1:0];
	end

endmodule

### hw/rtl/modexp_ctrl.sv
// Sequencer of the core: walks the base reduction and the multiply and square passes.
// Depends on modexp_pkg for the state, operation, status and command types.

module modexp_ctrl #(
	parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  modexp_pkg::status_t status,
	output modexp_pkg::ctrl_t   ctrl
);

	modexp_pkg::state_t                   state_q;
	modexp_pkg::state_t                   state_next;
	logic [modexp_pkg::CNT_WIDTH-1:0]     cnt_q;
	logic                                 cnt_zero;

	assign cnt_zero = (cnt_q == '0);

	always_comb begin
		state_next = state_q;
		case (state_q)
			modexp_pkg::ST_IDLE: begin
				if (status.in_valid) begin
					state_next = status.skip ? modexp_pkg::ST_FINISH : modexp_pkg::ST_REDUCE;
				end
			end
			modexp_pkg::ST_REDUCE: begin
				if (cnt_zero) begin
					state_next = modexp_pkg::ST_CHECK;
				end
			end
			modexp_pkg::ST_CHECK: begin
				if (status.exp_zero) begin
					state_next = modexp_pkg::ST_FINISH;
				end else if (status.exp_lsb) begin
					state_next = modexp_pkg::ST_MUL;
				end else begin
					state_next = modexp_pkg::ST_SQR;
				end
			end
			modexp_pkg::ST_MUL: begin
				if (cnt_zero) begin
					state_next = status.exp_last ? modexp_pkg::ST_CHECK : modexp_pkg::ST_SQR;
				end
			end
			modexp_pkg::ST_SQR: begin
				if (cnt_zero) begin
					state_next = modexp_pkg::ST_CHECK;
				end
			end
			modexp_pkg::ST_FINISH: begin
				if (status.out_free) begin
					state_next = modexp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = modexp_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.op = modexp_pkg::OP_REDUCE;
		case (state_q)
			modexp_pkg::ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				ctrl.load     = status.in_valid;
			end
			modexp_pkg::ST_REDUCE: begin
				ctrl.step = 1'b1;
				ctrl.last = cnt_zero;
				ctrl.op   = modexp_pkg::OP_REDUCE;
			end
			modexp_pkg::ST_CHECK: begin
				ctrl.start_mul = !status.exp_zero && status.exp_lsb;
				ctrl.start_sqr = !status.exp_zero && !status.exp_lsb;
			end
			modexp_pkg::ST_MUL: begin
				ctrl.step      = 1'b1;
				ctrl.last      = cnt_zero;
				ctrl.op        = modexp_pkg::OP_MUL;
				// The square after the top exponent bit would never be used.
				ctrl.start_sqr = cnt_zero && !status.exp_last;
				ctrl.shift_exp = cnt_zero && status.exp_last;
			end
			modexp_pkg::ST_SQR: begin
				ctrl.step      = 1'b1;
				ctrl.last      = cnt_zero;
				ctrl.op        = modexp_pkg::OP_SQR;
				ctrl.shift_exp = cnt_zero;
			end
			modexp_pkg::ST_FINISH: begin
				ctrl.finish = status.out_free;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= modexp_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_next;
			if (ctrl.load) begin
				cnt_q <= modexp_pkg::CNT_WIDTH'(modexp_pkg::BASE_WIDTH - 1);
			end else if (ctrl.start_mul || ctrl.start_sqr) begin
				cnt_q <= modexp_pkg::CNT_WIDTH'(MOD_WIDTH - 1);
			end else if (ctrl.step && !cnt_zero) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/modexp_checker.sv
// Port-level checker for the modular exponentiation core, with its bind statement.
// Depends on modexp_pkg and on the port list of modular_exponentiation_core.

module modexp_checker #(
	parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [modexp_pkg::RESULT_WIDTH-1:0] power_result
);

	// The core works on one item at a time, so ready drops right after a transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("operand accepted while a previous item was still in progress");

	// A new result is only produced by the sequencer's final state, when ready is low.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a computation in progress");

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(power_result))
		else $error("stalled result changed or was dropped");

	// Every result lies within the modulus width.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((power_result >> MOD_WIDTH) == '0))
		else $error("result wider than the modulus");

endmodule

bind modular_exponentiation_core modexp_checker #(
	.MOD_WIDTH (MOD_WIDTH)
) u_modexp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (operands.valid),
	.in_ready     (operands.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.power_result (result.power_result)
);

### tb/sv/modular_exponentiation_core_tb.sv
// Self-checking testbench for modular_exponentiation_core: a table of directed operands, then
// random operands under several moduli, each result checked against a typed value or a square-and-multiply model.
// Depends on modexp_pkg, the channel interfaces in modexp_if.sv and the core itself.

module modular_exponentiation_core_tb;

	localparam int unsigned N_RANDOM    = 267;
	localparam int unsigned N_DIRECTED  = 23;
	localparam int unsigned MAX_GAP     = 16;
	localparam int unsigned HOLD_AT     = 40;
	localparam int unsigned HOLD_CYCLES = 10000;
	// Covers the slowest full-width exponent; allow for both sides' gaps on top.
	localparam int unsigned TAIL_CYCLES = 4200;
	localparam int unsigned LIMIT =
		(N_DIRECTED + N_RANDOM) * (TAIL_CYCLES + 2 * MAX_GAP) * 4 + 4 * HOLD_CYCLES + 20000;
	localparam int unsigned REPORT_MAX  = 10;

	localparam logic [62:0] BMAX      = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [30:0] MOD_MAX   = 31'h7FFF_FFFF;
	localparam logic [30:0] MOD_PRIME = 31'd1000000007;

	// Moduli that the random part goes through, one per phase.
	typedef enum int unsigned {
		PLAN_RANDOM,
		PLAN_MAX,
		PLAN_TINY,
		PLAN_ONE,
		PLAN_ZERO,
		PLAN_PRIME,
		PLAN_HIGH,
		PLAN_COUNT
	} mod_plan_t;

	// One row of the directed table. Where typed is set, power is the result read straight
	// off the arithmetic; otherwise the row is checked against the predictor.
	typedef struct packed {
		logic        load_mod;
		logic [30:0] modulus;
		logic [62:0] base;
		logic [62:0] expo;
		logic        typed;
		logic [30:0] power;
	} vector_t;

	localparam vector_t DIRECTED [N_DIRECTED] = '{
		// Modulus after reset.
		'{1'b0, 31'd0,     63'd0,           63'd0,           1'b1, 31'd1},
		'{1'b0, 31'd0,     BMAX,            63'd0,           1'b1, 31'd1},
		'{1'b0, 31'd0,     63'd0,           63'd1,           1'b1, 31'd0},
		'{1'b0, 31'd0,     63'd1,           BMAX,            1'b1, 31'd1},
		'{1'b0, 31'd0,     63'd2,           63'd10,          1'b1, 31'd1024},
		'{1'b0, 31'd0,     BMAX,            BMAX,            1'b0, 31'd0},
		'{1'b0, 31'd0,     63'd1000000007,  63'd5,           1'b1, 31'd0},
		'{1'b0, 31'd0,     63'd1000000006,  63'd2,           1'b1, 31'd1},
		'{1'b0, 31'd0,     63'd3,           63'd1,           1'b1, 31'd3},
		// Largest modulus.
		'{1'b1, MOD_MAX,   BMAX,            BMAX,            1'b0, 31'd0},
		'{1'b0, 31'd0,     63'd2147483646,  63'd3,           1'b1, 31'd2147483646},
		'{1'b0, 31'd0,     63'd2,           63'd31,          1'b1, 31'd1},
		'{1'b0, 31'd0,     63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 31'd0},
		// Modulus of one.
		'{1'b1, 31'd1,     63'd5,           63'd0,           1'b1, 31'd1},
		'{1'b0, 31'd0,     63'd5,           63'd7,           1'b1, 31'd0},
		'{1'b0, 31'd0,     BMAX,            BMAX,            1'b1, 31'd0},
		// Modulus of zero: no reduction possible.
		'{1'b1, 31'd0,     63'd7,           63'd0,           1'b1, 31'd1},
		'{1'b0, 31'd0,     63'd7,           63'd3,           1'b1, 31'd0},
		'{1'b0, 31'd0,     BMAX,            BMAX,            1'b1, 31'd0},
		// Modulus of two.
		'{1'b1, 31'd2,     63'd3,           BMAX,            1'b1, 31'd1},
		'{1'b0, 31'd0,     63'd4,           63'd1,           1'b1, 31'd0},
		// Small prime.
		'{1'b1, 31'd97,    63'd5,           63'd96,          1'b1, 31'd1},
		'{1'b0, 31'd0,     63'd123456789,   63'h7000_0000_0000_0001, 1'b0, 31'd0}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 modulus_we;
	logic [modexp_pkg::MOD_WIDTH_DEF-1:0] modulus_wdata;

	modexp_in_if  operand_bus ();
	modexp_out_if result_bus ();

	modular_exponentiation_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.modulus_we    (modulus_we),
		.modulus_wdata (modulus_wdata),
		.operands      (operand_bus),
		.result        (result_bus)
	);

	// Powers still owed by the core, oldest first.
	logic [30:0]  pending_powers [$];
	logic [30:0]  active_modulus = modexp_pkg::MODULUS_RESET[30:0];

	int unsigned  operands_sent  = 0;
	int unsigned  modulus_writes = 0;
	int unsigned  powers_checked = 0;
	int unsigned  mismatches     = 0;
	int unsigned  stray_powers   = 0;
	int unsigned  reports        = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Right-to-left square-and-multiply over 64-bit words. The modulus is below 2^31, so
	// every product fits comfortably.
	function automatic logic [30:0] modpow_predict(input logic [62:0] base,
			input logic [62:0] expo, input logic [30:0] modulus);
		logic [63:0] m;
		logic [63:0] b;
		logic [63:0] acc;
		logic [62:0] e;
		m = {33'd0, modulus};
		e = expo;
		if (e == 63'd0)
			return 31'd1;
		if (m == 64'd0)
			return 31'd0;
		b   = {1'b0, base} % m;
		acc = 64'd1 % m;
		while (e != 63'd0) begin
			if (e[0])
				acc = (acc * b) % m;
			e = e >> 1;
			b = (b * b) % m;
		end
		return acc[30:0];
	endfunction

	// Idle cycles before the next transfer. Now and then a side switches into a calm stretch
	// in which it never idles, so that back-to-back transfers are seen as well.
	function automatic int unsigned draw_gap(inout bit calm);
		if ($urandom_range(0, 19) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic logic [62:0] rand63();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[62:0];
	endfunction

	// Most exponents are short so that the run stays brief; a tenth use the full width.
	function automatic logic [62:0] rand_exponent();
		int unsigned sel;
		int unsigned width;
		sel = $urandom_range(0, 99);
		if (sel < 3)
			return 63'd0;
		if (sel < 13)
			return rand63();
		width = (sel < 33) ? $urandom_range(13, 32) : $urandom_range(1, 12);
		return rand63() & ((63'd1 << width) - 63'd1);
	endfunction

	// Bases are full-width, small, 31-bit, or sit on or right beside a multiple of the modulus.
	function automatic logic [62:0] rand_base(input logic [30:0] modulus);
		int unsigned sel;
		logic [62:0] m;
		logic [62:0] k;
		sel = $urandom_range(0, 99);
		m = {32'd0, modulus};
		k = {31'd0, $urandom()};
		if (sel < 40 || modulus == 31'd0)
			return rand63();
		if (sel < 60)
			return 63'($urandom_range(0, 1000));
		if (sel < 75) begin
			case ($urandom_range(0, 2))
				0:       return k * m;
				1:       return k * m + 63'd1;
				default: return k * m + m - 63'd1;
			endcase
		end
		return {32'd0, 31'($urandom())};
	endfunction

	bit sender_calm = 1'b0;

	// Offer one operand pair and wait for its transfer. Called and returns at a falling edge;
	// valid is left high so that a zero gap gives back-to-back transfers.
	task automatic push_operands(input logic [62:0] base, input logic [62:0] expo,
			input logic [30:0] power);
		int unsigned gap;
		gap = draw_gap(sender_calm);
		if (gap != 0) begin
			operand_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		operand_bus.valid      <= 1'b1;
		operand_bus.base_value <= base;
		operand_bus.exponent   <= expo;
		do
			@(posedge clk);
		while (!(operand_bus.valid && operand_bus.ready));
		pending_powers = {pending_powers, power};
		operands_sent++;
		@(negedge clk);
	endtask

	// Stop offering and wait until every owed power has been collected; the core is idle then.
	task automatic await_all_powers();
		operand_bus.valid <= 1'b0;
		while (pending_powers.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_modulus(input logic [30:0] value);
		modulus_we     <= 1'b1;
		modulus_wdata  <= value;
		active_modulus  = value;
		modulus_writes++;
		@(negedge clk);
		modulus_we <= 1'b0;
	endtask

	function automatic logic [30:0] plan_modulus(input mod_plan_t plan);
		case (plan)
			PLAN_RANDOM: return 31'($urandom());
			PLAN_MAX:    return MOD_MAX;
			PLAN_TINY:   return 31'($urandom_range(2, 255));
			PLAN_ONE:    return 31'd1;
			PLAN_ZERO:   return 31'd0;
			PLAN_PRIME:  return MOD_PRIME;
			default:     return 31'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
		endcase
	endfunction

	// Stimulus: reset, the directed table, then one random phase per planned modulus.
	initial begin : stimulus
		logic [62:0] base;
		logic [62:0] expo;
		logic [30:0] power;
		int unsigned per_phase;
		int unsigned count;
		arst_n                 = 1'b0;
		modulus_we             = 1'b0;
		modulus_wdata          = '0;
		operand_bus.valid      = 1'b0;
		operand_bus.base_value = '0;
		operand_bus.exponent   = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Rows that change the modulus first let the core finish everything in flight.
		for (int k = 0; k < N_DIRECTED; k++) begin
			if (DIRECTED[k].load_mod) begin
				await_all_powers();
				write_modulus(DIRECTED[k].modulus);
			end
			power = DIRECTED[k].typed ? DIRECTED[k].power
				: modpow_predict(DIRECTED[k].base, DIRECTED[k].expo, active_modulus);
			push_operands(DIRECTED[k].base, DIRECTED[k].expo, power);
		end

		per_phase = N_RANDOM / PLAN_COUNT;
		for (int p = 0; p < PLAN_COUNT; p++) begin
			await_all_powers();
			write_modulus(plan_modulus(mod_plan_t'(p)));
			count = (p == PLAN_COUNT - 1) ? N_RANDOM - per_phase * (PLAN_COUNT - 1) : per_phase;
			for (int n = 0; n < count; n++) begin
				base = rand_base(active_modulus);
				expo = rand_exponent();
				push_operands(base, expo, modpow_predict(base, expo, active_modulus));
			end
		end

		await_all_powers();
		// Give a spurious extra result time to show up before judging the run.
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Covered %0d operand transfers under %0d modulus writes, from 0 and 1 up to 2^31-1.",
			operands_sent, modulus_writes);
		$display("%0d results checked: %0d wrong, %0d unexpected, %0d never delivered.",
			powers_checked, mismatches, stray_powers, pending_powers.size());
		if (mismatches == 0 && stray_powers == 0 && pending_powers.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Result side: random stalls, one long hold-off once the run is under way so that the core
	// fills up and refuses operands, and a check of every result transfer.
	initial begin : collector
		int unsigned gap;
		bit          calm;
		bit          held;
		logic [30:0] power;
		calm = 1'b0;
		held = 1'b0;
		result_bus.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap(calm);
			if (!held && powers_checked == HOLD_AT) begin
				held = 1'b1;
				result_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (gap != 0) begin
				result_bus.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_bus.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(result_bus.valid && result_bus.ready));

			if (pending_powers.size() == 0) begin
				stray_powers++;
				if (reports < REPORT_MAX)
					$display("unexpected result transfer: power_result %0d",
						result_bus.power_result);
				reports++;
			end else begin
				power = pending_powers[0];
				pending_powers.delete(0);
				powers_checked++;
				if (result_bus.power_result !== power) begin
					mismatches++;
					if (reports < REPORT_MAX)
						$display("power_result mismatch on result %0d: expected %0d, got %0d",
							powers_checked, power, result_bus.power_result);
					reports++;
				end
			end
			@(negedge clk);
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles with %0d results outstanding", cycles,
			pending_powers.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/modexp_pkg.sv
hw/rtl/modexp_if.sv
hw/rtl/modexp_step.sv
hw/rtl/modexp_ctrl.sv
hw/rtl/modular_exponentiation_core.sv
hw/rtl/modexp_checker.sv
tb/sv/modular_exponentiation_core_tb.sv
